/* rtl/sdss_pkg.sv */
`timescale 1ns / 1ps

package sdss_pkg;

    localparam int DISPLAY_COUNT = 8;
    // Only eight displays can be addressed with a 3-bit index.
    localparam int USED_COUNT = (DISPLAY_COUNT > 8) ? 8 : DISPLAY_COUNT;

    localparam int NUMBER_W = 28;
    localparam int MAG_W    = NUMBER_W - 1;
    localparam int DIGIT_W  = 4;
    localparam int POS_W    = 3;
    localparam int IDX_W    = 3;
    localparam int SEG_W    = 8;
    localparam int BCD_W    = 4 * USED_COUNT;
    localparam int CNT_W    = $clog2(MAG_W + 1);

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_ALL   = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    function automatic longint pow10(input int n);
        longint p;
        p = 1;
        for (int i = 0; i < n; i++)
        begin
            p = p * 10;
        end
        return p;
    endfunction

    localparam longint CLAMP_HI_L = pow10(USED_COUNT) - 1;
    localparam longint CLAMP_LO_L = -(pow10(USED_COUNT - 1) - 1);
    localparam logic signed [NUMBER_W-1:0] CLAMP_HI = CLAMP_HI_L[NUMBER_W-1:0];
    localparam logic signed [NUMBER_W-1:0] CLAMP_LO = CLAMP_LO_L[NUMBER_W-1:0];

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED_COUNT - 1);
    localparam logic [POS_W:0]   USED_POS = (POS_W + 1)'(USED_COUNT);

    typedef enum logic [1:0] {
        MODE_NUMBER = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_FILL   = 2'd2,
        MODE_DIGIT  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5B;
            4'd3:    s = 8'h4F;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6D;
            4'd6:    s = 8'h7D;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7F;
            4'd9:    s = 8'h67;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

/* rtl/sdss_bcd.sv */
`timescale 1ns / 1ps

module sdss_bcd
    import sdss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [MAG_W-1:0] mag,
    output logic             busy,
    output logic [BCD_W-1:0] bcd
);

    logic [MAG_W-1:0] bin_reg;
    logic [MAG_W-1:0] bin_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic [BCD_W-1:0] adj;

    // Shift-and-add-3: every digit of five or more is corrected before the shift.
    always_comb
    begin
        for (int i = 0; i < USED_COUNT; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = CNT_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bcd_next  = {adj[BCD_W-2:0], bin_reg[MAG_W-1]};
            bin_next  = {bin_reg[MAG_W-2:0], 1'b0};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = busy_reg;
    assign bcd  = bcd_reg;

endmodule

/* rtl/signed_decimal_seven_segment.sv */
`timescale 1ns / 1ps
// One item at a time: the input stalls until the last write of an item has been loaded.
// A show-number item is loaded, its 27-bit magnitude is converted bit-serially from binary
// to BCD, the digits are handed over, then up to eight writes follow at one write per cycle
// while the output does not stall. Clear and fill give eight writes, a single-digit write
// one, each at the same rate; an output stall holds the current write. The shift-and-add-3
// loop sets the length of a show-number item, the longest of the kinds of item.
// Reset (rst_n, asynchronous, active low) returns the block to idle with no write pending.

module signed_decimal_seven_segment
    import sdss_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 mode,
    input  logic signed [NUMBER_W-1:0] number,
    input  logic [DIGIT_W-1:0]         digit,
    input  logic [POS_W-1:0]           position,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [IDX_W-1:0]           display_index,
    output logic [SEG_W-1:0]           segments,
    output logic                       last
);

    state_t               state_reg, state_next;
    mode_t                mode_reg, mode_next;
    logic                 neg_reg, neg_next;
    logic                 sign_reg, sign_next;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [BCD_W-1:0]     dig_reg, dig_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [DIGIT_W-1:0]   digit_reg, digit_next;
    logic                 out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SEG_W-1:0]     seg_reg, seg_next;
    logic                 last_reg, last_next;

    logic                       accept;
    logic signed [NUMBER_W-1:0] clamped;
    logic [NUMBER_W-1:0]        abs_val;
    logic                       conv_start;
    logic                       conv_busy;
    logic [BCD_W-1:0]           conv_bcd;
    logic                       out_free;
    logic [IDX_W-1:0]           w_idx;
    logic [SEG_W-1:0]           w_seg;
    logic                       w_last;
    logic                       w_sign;
    logic                       num_done;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (number > CLAMP_HI)
        begin
            clamped = CLAMP_HI;
        end
        else if (number < CLAMP_LO)
        begin
            clamped = CLAMP_LO;
        end
        else
        begin
            clamped = number;
        end
        abs_val = clamped[NUMBER_W-1] ? (~clamped + 1'b1) : clamped;
    end

    assign conv_start = accept && (mode_t'(mode) == MODE_NUMBER);

    sdss_bcd u_bcd
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (abs_val[MAG_W-1:0]),
        .busy  (conv_busy),
        .bcd   (conv_bcd)
    );

    // The write that the current emit step would produce.
    always_comb
    begin
        w_idx    = k_reg;
        w_seg    = SEG_BLANK;
        w_last   = 1'b0;
        w_sign   = 1'b0;
        num_done = (dig_reg[BCD_W-1:4] == '0) || (k_reg == LAST_IDX);
        case (mode_reg)
            MODE_NUMBER:
            begin
                if (sign_reg)
                begin
                    w_seg  = SEG_MINUS;
                    w_last = 1'b1;
                end
                else
                begin
                    w_seg = seg_of(dig_reg[3:0]);
                    if (num_done && neg_reg && (k_reg != LAST_IDX))
                    begin
                        w_sign = 1'b1;
                    end
                    else
                    begin
                        w_last = num_done;
                    end
                end
            end
            MODE_CLEAR:
            begin
                w_seg  = SEG_BLANK;
                w_last = (k_reg == LAST_IDX);
            end
            MODE_FILL:
            begin
                w_seg  = SEG_ALL;
                w_last = (k_reg == LAST_IDX);
            end
            default:
            begin
                w_idx  = pos_reg;
                w_seg  = seg_of(digit_reg);
                w_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        neg_next       = neg_reg;
        sign_next      = sign_reg;
        k_next         = k_reg;
        dig_next       = dig_reg;
        pos_next       = pos_reg;
        digit_next     = digit_reg;
        out_valid_next = out_valid_reg && out_stall;
        idx_next       = idx_reg;
        seg_next       = seg_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next  = mode_t'(mode);
                    neg_next   = clamped[NUMBER_W-1];
                    sign_next  = 1'b0;
                    k_next     = '0;
                    pos_next   = position;
                    digit_next = digit;
                    if (mode_t'(mode) == MODE_NUMBER)
                    begin
                        state_next = ST_CONV;
                    end
                    else if ((mode_t'(mode) == MODE_DIGIT) && ({1'b0, position} >= USED_POS))
                    begin
                        // A position beyond the row produces no write at all.
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_CONV:
            begin
                if (!conv_busy)
                begin
                    dig_next   = conv_bcd;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    idx_next       = w_idx;
                    seg_next       = w_seg;
                    last_next      = w_last;
                    k_next         = k_reg + 1'b1;
                    dig_next       = {4'b0, dig_reg[BCD_W-1:4]};
                    sign_next      = w_sign;
                    if (w_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        neg_reg   <= neg_next;
        sign_reg  <= sign_next;
        k_reg     <= k_next;
        dig_reg   <= dig_next;
        pos_reg   <= pos_next;
        digit_reg <= digit_next;
        idx_reg   <= idx_next;
        seg_reg   <= seg_next;
        last_reg  <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign display_index = idx_reg;
    assign segments      = seg_reg;
    assign last          = last_reg;

endmodule
